[sv/rgb_framebuffer_draw_engine_macros.svh]
// Assertion helpers for the draw engine.
`ifndef RGB_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define RGB_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("draw engine assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("draw engine assertion failed");

`endif

[sv/rgbfb_pkg.sv]
package rgbfb_pkg;

  localparam int unsigned CHAN_W   = 20;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned FACT_W   = 9;
  localparam int unsigned PROD_W   = CHAN_W + FACT_W;
  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned COORD_W  = 3;

  localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_SET   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIM   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SCALE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd4;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] word_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic signed [7:0]  x_pos;
    logic signed [7:0]  y_pos;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
    logic [FACT_W-1:0]  factor;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_out;
    logic [COORD_W-1:0] y_out;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic               last_pixel;
  } pix_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              mul_en;
  } alu_ctl_t;

endpackage

[sv/rgbfb_chan_alu.sv]
// Shared channel unit: one registered multiply, then align, add, saturate or round.
module rgbfb_chan_alu #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                                  clk_i,
  input  rgbfb_pkg::alu_ctl_t                   ctl_i,
  input  logic [rgbfb_pkg::CHAN_W-1:0]          oper_i,
  input  logic [rgbfb_pkg::FACT_W-1:0]          factor_i,
  input  logic [rgbfb_pkg::CHAN_W-1:0]          old_i,
  output logic [rgbfb_pkg::CHAN_W-1:0]          res_o
);

  localparam int unsigned CW    = rgbfb_pkg::CHAN_W;
  localparam int unsigned PW    = rgbfb_pkg::PROD_W;
  localparam int unsigned SHL   = (FRACTION_BITS >= 8) ? FRACTION_BITS - 8 : 0;
  localparam int unsigned SHR   = (FRACTION_BITS >= 8) ? 0 : 8 - FRACTION_BITS;
  localparam int unsigned ALN_W = PW + SHL;
  localparam logic [CW:0] HALF  = (CW+1)'(1) << (FRACTION_BITS - 1);

  logic [PW-1:0]    prod_q;
  logic [ALN_W-1:0] aligned;
  logic [CW-1:0]    term;
  logic [CW:0]      sum;
  logic [CW-1:0]    scaled;
  logic [PW-9:0]    shifted;
  logic [CW:0]      rnd;
  logic [CW:0]      rnd_sh;
  logic [7:0]       byte_val;

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= PW'(oper_i) * PW'(factor_i);
    end
  end

  // Align the color term to the channel format and saturate; also form the sum, scaled and rounded values
  always_comb begin
    aligned = (ALN_W'(prod_q) << SHL) >> SHR;
    term    = (|aligned[ALN_W-1:CW]) ? rgbfb_pkg::CHAN_MAX : aligned[CW-1:0];
    sum     = {1'b0, old_i} + {1'b0, term};
    shifted = prod_q[PW-1:8];
    scaled  = (|shifted[PW-9:CW]) ? rgbfb_pkg::CHAN_MAX : shifted[CW-1:0];
    rnd     = {1'b0, old_i} + HALF;
    rnd_sh  = rnd >> FRACTION_BITS;
    byte_val = (|rnd_sh[CW:8]) ? 8'hFF : rnd_sh[7:0];
  end

  // Select the result for the command kind
  always_comb begin
    unique case (ctl_i.kind) inside
      rgbfb_pkg::KIND_SET:   res_o = term;
      rgbfb_pkg::KIND_ADD:   res_o = sum[CW] ? rgbfb_pkg::CHAN_MAX : sum[CW-1:0];
      rgbfb_pkg::KIND_DIM, rgbfb_pkg::KIND_SCALE: res_o = scaled;
      rgbfb_pkg::KIND_FLUSH: res_o = CW'(byte_val);
      default:               res_o = old_i;
    endcase
  end

endmodule

[sv/rgb_framebuffer_draw_engine.sv]
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | in_item_i  (rgbfb_pkg::cmd_t)
// out     | output    | out_valid_o / out_ready_i | out_item_o (rgbfb_pkg::pix_t)
//
// Each pixel visit is a frame store read, a multiply and a combine step per channel
// through one shared unit, then a write (or output load on flush).
// Set, add and dim visit one pixel; scale-all and flush visit every pixel in turn;
// off-panel and unused kinds end in the accept cycle. Ready only in idle.
// Reset clears every pixel at once through per-pixel valid bits.
// A flush stalls on a pixel while the output register still holds an untaken item.
`include "rgb_framebuffer_draw_engine_macros.svh"

module rgb_framebuffer_draw_engine #(
  parameter int unsigned PANEL_WIDTH   = 8,
  parameter int unsigned PANEL_HEIGHT  = 8,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rgbfb_pkg::cmd_t     in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rgbfb_pkg::pix_t     out_item_o
);

  localparam int unsigned PIXELS = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int unsigned AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned CW     = rgbfb_pkg::CHAN_W;
  localparam int unsigned XYW    = rgbfb_pkg::COORD_W;
  localparam logic [AW-1:0]  LAST_ADDR = AW'(PIXELS - 1);
  localparam logic [XYW-1:0] LAST_X    = XYW'(PANEL_WIDTH - 1);
  localparam logic [XYW-1:0] LAST_Y    = XYW'(PANEL_HEIGHT - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]           state_q, state_d;
  rgbfb_pkg::cmd_t      cmd_q;
  logic [AW-1:0]        addr_q;
  logic [XYW-1:0]       x_q, y_q;
  logic [1:0]           chan_q;
  rgbfb_pkg::word_t     res_q;
  rgbfb_pkg::word_t     rd_q;
  logic                 rd_vld_q;
  logic [PIXELS-1:0]    vld_q;
  rgbfb_pkg::word_t     mem [PIXELS];
  logic                 out_valid_q;
  rgbfb_pkg::pix_t      out_q;

  logic                 accept;
  logic                 x_ok, y_ok;
  logic [AW-1:0]        cmd_addr;
  logic                 mem_we;
  logic                 is_last;
  logic                 out_free;
  logic                 load_out;
  rgbfb_pkg::alu_ctl_t  alu_ctl;
  logic [CW-1:0]        old_chan;
  logic [CW-1:0]        alu_oper;
  logic [CW-1:0]        alu_res;
  logic [rgbfb_pkg::COLOR_W-1:0] color;
  logic                 is_flush;
  logic                 last_corner;
  logic                 chan_end;
  logic                 pix_end;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Decode the target pixel of a single-pixel command
  assign x_ok     = !in_item_i.x_pos[7] && (in_item_i.x_pos[6:0] < 7'(PANEL_WIDTH));
  assign y_ok     = !in_item_i.y_pos[7] && (in_item_i.y_pos[6:0] < 7'(PANEL_HEIGHT));
  assign cmd_addr = AW'(int'(in_item_i.y_pos[XYW-1:0]) * PANEL_WIDTH
                        + int'(in_item_i.x_pos[XYW-1:0]));

  assign is_last  = (addr_q == LAST_ADDR);
  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = (state_q == S_EMIT) && out_free;
  assign mem_we   = (state_q == S_WRITE);

  // Feed the shared unit
  always_comb begin
    old_chan = rd_vld_q ? rd_q[chan_q] : '0;
    case (chan_q)
      2'd0:    color = cmd_q.red_in;
      2'd1:    color = cmd_q.green_in;
      default: color = cmd_q.blue_in;
    endcase
    if (cmd_q.kind == rgbfb_pkg::KIND_SET || cmd_q.kind == rgbfb_pkg::KIND_ADD) begin
      alu_oper = CW'(color);
    end else begin
      alu_oper = old_chan;
    end
    alu_ctl.kind   = cmd_q.kind;
    alu_ctl.mul_en = (state_q == S_MUL);
  end

  rgbfb_chan_alu #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_alu (
    .clk_i   (clk_i),
    .ctl_i   (alu_ctl),
    .oper_i  (alu_oper),
    .factor_i(cmd_q.factor),
    .old_i   (old_chan),
    .res_o   (alu_res)
  );

  // Sequence the pixel visits
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item_i.kind) inside
            rgbfb_pkg::KIND_SET, rgbfb_pkg::KIND_ADD, rgbfb_pkg::KIND_DIM:
              state_d = (x_ok && y_ok) ? S_READ : S_IDLE;
            rgbfb_pkg::KIND_SCALE, rgbfb_pkg::KIND_FLUSH:
              state_d = S_READ;
            default:
              state_d = S_IDLE;
          endcase
        end
      end
      S_READ:  state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC: begin
        if (chan_q == 2'd2) begin
          state_d = (cmd_q.kind == rgbfb_pkg::KIND_FLUSH) ? S_EMIT : S_WRITE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_WRITE: begin
        state_d = (cmd_q.kind == rgbfb_pkg::KIND_SCALE && !is_last) ? S_READ : S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = is_last ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk the pixel address, coordinates and channel index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      chan_q <= '0;
    end else begin
      if (accept) begin
        addr_q <= (in_item_i.kind == rgbfb_pkg::KIND_SCALE ||
                   in_item_i.kind == rgbfb_pkg::KIND_FLUSH) ? '0 : cmd_addr;
        x_q    <= '0;
        y_q    <= '0;
      end else if ((mem_we || load_out) && !is_last) begin
        addr_q <= addr_q + AW'(1);
        if (x_q == LAST_X) begin
          x_q <= '0;
          y_q <= y_q + XYW'(1);
        end else begin
          x_q <= x_q + XYW'(1);
        end
      end
      if (state_q == S_READ) begin
        chan_q <= '0;
      end else if (state_q == S_ACC) begin
        chan_q <= chan_q + 2'd1;
      end
    end
  end

  // Latch the command payload and channel results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_item_i;
    end
    if (state_q == S_ACC) begin
      res_q[chan_q] <= alu_res;
    end
  end

  // Frame store: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= res_q;
    end
    rd_q <= mem[addr_q];
  end

  // Mark written pixels; an unmarked pixel reads as black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[addr_q] <= 1'b1;
      end
      rd_vld_q <= vld_q[addr_q];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.x_out      <= x_q;
      out_q.y_out      <= y_q;
      out_q.red_out    <= res_q[0][7:0];
      out_q.green_out  <= res_q[1][7:0];
      out_q.blue_out   <= res_q[2][7:0];
      out_q.last_pixel <= is_last;
    end
  end

  // Checks
  assign is_flush    = (cmd_q.kind == rgbfb_pkg::KIND_FLUSH);
  assign last_corner = (out_q.x_out == LAST_X) && (out_q.y_out == LAST_Y);
  assign chan_end    = (state_q == S_ACC) && (chan_q == 2'd2);
  assign pix_end     = (state_q == S_WRITE) || (state_q == S_EMIT);

  `RFDE_ASSERT_NOW(a_emit_only_flush, clk_i, rst_ni, state_q == S_EMIT, is_flush)
  `RFDE_ASSERT_NOW(a_no_write_on_flush, clk_i, rst_ni, mem_we, !is_flush)
  `RFDE_ASSERT_NOW(a_last_at_corner, clk_i, rst_ni, out_valid_q && out_q.last_pixel, last_corner)
  `RFDE_ASSERT_NEXT(a_chan_wraps, clk_i, rst_ni, chan_end, pix_end)

endmodule
